[sv/brc_pkg.sv]
// Shared types, constants and arithmetic helpers of the brightness-ratio recolor unit.
`default_nettype none
package brc_pkg;

  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int NUM_CHAN   = 3;
  localparam int PROD_W     = 2 * CHAN_W;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = CHAN_W / DIV_STEPS;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  localparam logic [9:0]  DIV3_MUL   = 10'd683;
  localparam int          DIV3_SHIFT = 11;

  localparam logic [1:0] REG_MID = 2'd0;
  localparam logic [1:0] REG_MAX = 2'd1;
  localparam logic [1:0] REG_MIN = 2'd2;
  localparam logic [1:0] REG_REF = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] low;
  } lane_t;

  typedef struct packed {
    logic [PIX_W-1:0]  src;
    logic [CHAN_W-1:0] dvs;
    lane_t [NUM_CHAN-1:0] lane;
  } div_t;

  // Truncated mean of the three channels; multiply by 683/2048 is exact for sums up to 765.
  function automatic logic [CHAN_W-1:0] brightness(input logic [PIX_W-1:0] c);
    logic [9:0]  s;
    logic [19:0] p;
    s = 10'(c[23:16]) + 10'(c[15:8]) + 10'(c[7:0]);
    p = 20'(s) * 20'(DIV3_MUL);
    return p[DIV3_SHIFT+CHAN_W-1:DIV3_SHIFT];
  endfunction

  // One restoring division step: brings in the next numerator bit, shifts in a quotient bit.
  function automatic lane_t div_step(input lane_t ln, input logic [CHAN_W-1:0] d);
    lane_t          r;
    logic [CHAN_W:0] t;
    logic           q;
    t = {ln.rem, ln.low[CHAN_W-1]};
    q = 1'b0;
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
      q = 1'b1;
    end
    r.rem = t[CHAN_W-1:0];
    r.low = {ln.low[CHAN_W-2:0], q};
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/brc_div_stage.sv]
// One pipeline stage of the three-lane divider, resolving two quotient bits per lane.
`default_nettype none
module brc_div_stage (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire brc_pkg::div_t d_i,
  output brc_pkg::div_t      d_o
);
  import brc_pkg::*;

  div_t d_r;
  div_t d_nxt;

  always_comb begin
    d_nxt = d_i;
    for (int k = 0; k < NUM_CHAN; k++) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        d_nxt.lane[k] = div_step(d_nxt.lane[k], d_i.dvs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule
`default_nettype wire

[sv/brightness_ratio_recolor_unit.sv]
// Top level of the brightness-ratio recolor unit.
`default_nettype none
// Recolors one 24-bit pixel per clock unless the output stalls. Each request passes
// through seven register stages: pixel brightness, blend products, numerator sum,
// then a four-stage restoring divider that resolves two quotient bits per stage for
// all three channels at once. Every stage holds a valid bit and a stage takes new
// data whenever it is empty or its successor moves, so a stalled output still lets
// requests fill empty stages.
// Write the color registers only while no request is in flight.
module brightness_ratio_recolor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // pixel_color
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // source_color, mapped_color
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_wdata
);
  import brc_pkg::*;

  localparam int NSTG = 3 + DIV_STAGES;

  logic [PIX_W-1:0]  mid_r, max_r, min_r, refc_r;
  logic [CHAN_W-1:0] ref_r;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] rdy;

  logic [PIX_W-1:0]  s1_src_r;
  logic [CHAN_W-1:0] s1_a_r;

  logic [PIX_W-1:0]  s2_src_r;
  logic [CHAN_W-1:0] s2_dvs_r;
  logic [PROD_W-1:0] s2_p1_r [NUM_CHAN];
  logic [PROD_W-1:0] s2_p2_r [NUM_CHAN];
  logic [PROD_W-1:0] s2_p1_nxt [NUM_CHAN];
  logic [PROD_W-1:0] s2_p2_nxt [NUM_CHAN];
  logic [CHAN_W-1:0] s2_dvs_nxt;
  logic              lower;

  div_t dv [DIV_STAGES+1];
  div_t dv0_nxt;
  div_t dv0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r  <= '0;
      max_r  <= '0;
      min_r  <= '0;
      refc_r <= '0;
      ref_r  <= '0;
    end else begin
      ref_r <= brightness(refc_r);
      if (cfg_we) begin
        case (cfg_index)
          REG_MID: mid_r  <= cfg_wdata;
          REG_MAX: max_r  <= cfg_wdata;
          REG_MIN: min_r  <= cfg_wdata;
          REG_REF: refc_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_src_r <= in_tdata;
      s1_a_r   <= brightness(in_tdata);
    end
  end

  always_comb begin
    logic [CHAN_W-1:0] w1, w2, c1, c2;
    lower = (ref_r != '0) && (s1_a_r <= ref_r);
    s2_dvs_nxt = lower ? ref_r : CHAN_MAX - ref_r;
    w1 = lower ? s1_a_r : CHAN_MAX - s1_a_r;
    w2 = lower ? ref_r - s1_a_r : s1_a_r - ref_r;
    for (int k = 0; k < NUM_CHAN; k++) begin
      c1 = mid_r[k*CHAN_W +: CHAN_W];
      c2 = lower ? min_r[k*CHAN_W +: CHAN_W] : max_r[k*CHAN_W +: CHAN_W];
      s2_p1_nxt[k] = PROD_W'(w1) * PROD_W'(c1);
      s2_p2_nxt[k] = PROD_W'(w2) * PROD_W'(c2);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_src_r <= s1_src_r;
      s2_dvs_r <= s2_dvs_nxt;
      for (int k = 0; k < NUM_CHAN; k++) begin
        s2_p1_r[k] <= s2_p1_nxt[k];
        s2_p2_r[k] <= s2_p2_nxt[k];
      end
    end
  end

  // The weights of each blend add up to the divisor, so the sum stays below 256 times it.
  always_comb begin
    logic [PROD_W:0] num;
    dv0_nxt.src = s2_src_r;
    dv0_nxt.dvs = s2_dvs_r;
    for (int k = 0; k < NUM_CHAN; k++) begin
      num = {1'b0, s2_p1_r[k]} + {1'b0, s2_p2_r[k]};
      dv0_nxt.lane[k].rem = num[PROD_W-1:CHAN_W];
      dv0_nxt.lane[k].low = num[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      dv0_r <= dv0_nxt;
    end
  end

  assign dv[0] = dv0_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    brc_div_stage u_stage (
      .clk (clk),
      .en  (rdy[3+g]),
      .d_i (dv[g]),
      .d_o (dv[g+1])
    );
  end

  assign out_tvalid = v_r[NSTG-1];
  assign out_tdata  = {dv[DIV_STAGES].lane[2].low,
                       dv[DIV_STAGES].lane[1].low,
                       dv[DIV_STAGES].lane[0].low,
                       dv[DIV_STAGES].src};

endmodule
`default_nettype wire

[sim/brc_checker.sv]
// Watches the pixel, result and register ports, predicts each recolored pixel and compares.
module brc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [brc_pkg::PIX_W-1:0]   in_tdata,   // pixel_color
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [2*brc_pkg::PIX_W-1:0] out_tdata,  // source_color, mapped_color
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [brc_pkg::PIX_W-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import brc_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] mapped;
    logic [PIX_W-1:0] src;
  } recolor_t;

  logic [PIX_W-1:0] mid_c = '0;
  logic [PIX_W-1:0] max_c = '0;
  logic [PIX_W-1:0] min_c = '0;
  logic [PIX_W-1:0] ref_c = '0;
  recolor_t expected_colors[$];
  int mismatches = 0;

  function automatic int luma_of(input logic [PIX_W-1:0] c);
    int s;
    s = int'(c[23:16]) + int'(c[15:8]) + int'(c[7:0]);
    return s / 3;
  endfunction

  function automatic logic [PIX_W-1:0] recolor(input logic [PIX_W-1:0] px);
    int ref_b;
    int a;
    int m;
    int lo;
    int hi;
    int c;
    logic [PIX_W-1:0] res;
    ref_b = luma_of(ref_c);
    a = luma_of(px);
    res = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      m = int'(mid_c[8*k +: 8]);
      lo = int'(min_c[8*k +: 8]);
      hi = int'(max_c[8*k +: 8]);
      if (ref_b != 0 && a <= ref_b) begin
        c = (a * m + (ref_b - a) * lo) / ref_b;
      end else if (ref_b != 255) begin
        c = ((255 - a) * m + (a - ref_b) * hi) / (255 - ref_b);
      end else begin
        c = 0;
      end
      if (c > 255) begin
        c = 255;
      end
      res[8*k +: 8] = 8'(c);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    recolor_t got;
    recolor_t want;
    if (!rst_n) begin
      mid_c = '0;
      max_c = '0;
      min_c = '0;
      ref_c = '0;
      expected_colors.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        want.src = in_tdata;
        want.mapped = recolor(in_tdata);
        expected_colors.insert(expected_colors.size(), want);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MID: mid_c = cfg_wdata;
          REG_MAX: max_c = cfg_wdata;
          REG_MIN: min_c = cfg_wdata;
          REG_REF: ref_c = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_colors.size() == 0) begin
          fail_count++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: source %h mapped %h", got.src, got.mapped);
          end
        end else begin
          want = expected_colors.pop_front();
          if (got.src !== want.src || got.mapped !== want.mapped) begin
            fail_count++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: source %h mapped %h, expected source %h mapped %h",
                       got.src, got.mapped, want.src, want.mapped);
            end
          end
        end
      end
    end
    pending = expected_colors.size();
  end

endmodule

[sim/tb_brightness_ratio_recolor_unit.sv]
// Testbench top: drives pixels and color registers into the recolor unit and reports the verdict.
module tb_brightness_ratio_recolor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import brc_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [23:0]      in_tdata = '0;    // pixel_color
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [47:0]      out_tdata;        // source_color, mapped_color
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_MID;
  logic [23:0]      cfg_wdata = '0;
  int               fail_count;
  int               pending;
  bit               idle_on = 1'b1;
  int               stall_left = 0;

  logic [23:0] corner_px[7] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                24'h0000FF, 24'h000002, 24'h000003};
  logic [23:0] near_px[8] = '{24'h7F7F7F, 24'h7F8080, 24'h808080, 24'h808081,
                              24'h818181, 24'h000000, 24'hFFFFFF, 24'h8181FF};

  always #4 clk = ~clk;

  brightness_ratio_recolor_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  brc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_pixel(input logic [23:0] px);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_colors(input logic [23:0] mid, input logic [23:0] max,
                            input logic [23:0] min, input logic [23:0] refc);
    write_reg(REG_MID, mid);
    write_reg(REG_MAX, max);
    write_reg(REG_MIN, min);
    write_reg(REG_REF, refc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] clamp8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  // 4 draws in 10 give pixels near the reference brightness, where the blend switches.
  function automatic logic [23:0] random_pixel(input int level);
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      return ($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF;
    end else if (mode <= 4) begin
      return {clamp8(level + $urandom_range(0, 4) - 2),
              clamp8(level + $urandom_range(0, 4) - 2),
              clamp8(level + $urandom_range(0, 4) - 2)};
    end
    return 24'($urandom());
  endfunction

  initial begin
    logic [23:0] refc;
    int level;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    set_colors(24'h4080C0, 24'hFFFFFF, 24'h000000, 24'h000000);
    foreach (corner_px[i]) push_pixel(corner_px[i]);
    wait_drained();
    set_colors(24'hF0E0D0, 24'h123456, 24'h102030, 24'hFFFFFF);
    foreach (corner_px[i]) push_pixel(corner_px[i]);
    wait_drained();
    set_colors(24'h00FF80, 24'hFF00FF, 24'h80FF00, 24'h808080);
    foreach (near_px[i]) push_pixel(near_px[i]);

    for (int ph = 0; ph < 11; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          refc = 24'h000000;
          set_colors(24'h000000, 24'h000000, 24'h000000, refc);
        end
        1: begin
          refc = 24'hFFFFFF;
          set_colors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, refc);
        end
        2: begin
          refc = 24'h010101;
          set_colors(24'($urandom()), 24'($urandom()), 24'($urandom()), refc);
        end
        3: begin
          refc = 24'hFEFEFE;
          set_colors(24'($urandom()), 24'($urandom()), 24'($urandom()), refc);
        end
        default: begin
          if (ph % 2 == 1) begin
            level = $urandom_range(0, 255);
            refc = {8'(level), 8'(level), 8'(level)};
          end else begin
            refc = 24'($urandom());
          end
          set_colors(24'($urandom()), 24'($urandom()), 24'($urandom()), refc);
        end
      endcase
      level = (int'(refc[23:16]) + int'(refc[15:8]) + int'(refc[7:0])) / 3;
      idle_on = (ph != 10);
      repeat (130) push_pixel(random_pixel(level));
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
